// File: hw/rtl/snsg_pkg.sv
// ----------------------------------------------------------------------------
// snsg_pkg: shared codes and types of the nod / shake gesture detector
// operation, verdict and register codes, marker slots, duration windows
// ----------------------------------------------------------------------------
package snsg_pkg;

    localparam int OP_W       = 3;
    localparam int STICK_W    = 16;
    localparam int THR_W      = 15;
    localparam int MS_W       = 16;
    localparam int VERDICT_W  = 2;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MARKERS    = 6;
    localparam int MK_IDX_W   = 3;

    // operation codes
    localparam logic [OP_W-1:0] OP_X_SAMPLE = 3'd0;
    localparam logic [OP_W-1:0] OP_Y_SAMPLE = 3'd1;
    localparam logic [OP_W-1:0] OP_TICK     = 3'd2;
    localparam logic [OP_W-1:0] OP_ENABLE   = 3'd3;
    localparam logic [OP_W-1:0] OP_DISABLE  = 3'd4;

    // verdict codes
    localparam logic [VERDICT_W-1:0] VERDICT_NONE    = 2'd0;
    localparam logic [VERDICT_W-1:0] VERDICT_YES     = 2'd1;
    localparam logic [VERDICT_W-1:0] VERDICT_NO      = 2'd2;
    localparam logic [VERDICT_W-1:0] VERDICT_TIMEOUT = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEAD_THR    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EXTREME_THR = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_EXTREME = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_EXTREME = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_TOTAL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 3'd6;

    // register reset values in milliseconds
    localparam logic [MS_W-1:0] RST_MIN_EXTREME = 16'd200;
    localparam logic [MS_W-1:0] RST_MAX_EXTREME = 16'd1000;
    localparam logic [MS_W-1:0] RST_MIN_TOTAL   = 16'd500;
    localparam logic [MS_W-1:0] RST_MAX_TOTAL   = 16'd2000;
    localparam logic [MS_W-1:0] RST_TIMEOUT     = 16'd5000;

    // marker slots within one axis
    localparam logic [MK_IDX_W-1:0] MK_START_DEAD = 3'd0;
    localparam logic [MK_IDX_W-1:0] MK_END_DEAD   = 3'd1;
    localparam logic [MK_IDX_W-1:0] MK_NEG_START  = 3'd2;
    localparam logic [MK_IDX_W-1:0] MK_NEG_END    = 3'd3;
    localparam logic [MK_IDX_W-1:0] MK_POS_START  = 3'd4;
    localparam logic [MK_IDX_W-1:0] MK_POS_END    = 3'd5;

    typedef struct packed {
        logic [THR_W-1:0] dead;
        logic [THR_W-1:0] extreme;
        logic [MS_W-1:0]  min_extreme;
        logic [MS_W-1:0]  max_extreme;
        logic [MS_W-1:0]  min_total;
        logic [MS_W-1:0]  max_total;
    } t_axis_cfg;

endpackage

// File: hw/rtl/snsg_axis.sv
// ----------------------------------------------------------------------------
// snsg_axis: marker update of one stick axis
// places extreme and centre markers for one sample and drops them all
// when a dwell or the whole stroke leaves its duration window
// ----------------------------------------------------------------------------
module snsg_axis #(
    parameter int TIME_WIDTH = 32
) (
    input  snsg_pkg::t_axis_cfg                    i_cfg,
    input  logic signed [snsg_pkg::STICK_W-1:0]    i_v,
    input  logic [TIME_WIDTH-1:0]                  i_t,
    input  logic [snsg_pkg::MARKERS-1:0]           i_valid,
    input  logic [TIME_WIDTH-1:0]                  i_times [snsg_pkg::MARKERS],
    output logic [snsg_pkg::MARKERS-1:0]           o_valid,
    output logic [TIME_WIDTH-1:0]                  o_times [snsg_pkg::MARKERS]
);

    function automatic logic [TIME_WIDTH-1:0] abs_diff(input logic [TIME_WIDTH-1:0] a,
                                                       input logic [TIME_WIDTH-1:0] b);
        abs_diff = (a > b) ? a - b : b - a;
    endfunction

    function automatic logic out_of(input logic [TIME_WIDTH-1:0]    d,
                                    input logic [snsg_pkg::MS_W-1:0] lo,
                                    input logic [snsg_pkg::MS_W-1:0] hi);
        out_of = (d < TIME_WIDTH'(lo)) || (d > TIME_WIDTH'(hi));
    endfunction

    logic signed [snsg_pkg::STICK_W:0] v_w;
    logic signed [snsg_pkg::STICK_W:0] ext_pos;
    logic signed [snsg_pkg::STICK_W:0] ext_neg;
    logic signed [snsg_pkg::STICK_W:0] dead_pos;
    logic signed [snsg_pkg::STICK_W:0] dead_neg;
    logic                              centred;

    assign v_w      = {i_v[snsg_pkg::STICK_W-1], i_v};
    assign ext_pos  = {2'b00, i_cfg.extreme};
    assign ext_neg  = -ext_pos;
    assign dead_pos = {2'b00, i_cfg.dead};
    assign dead_neg = -dead_pos;
    assign centred  = (v_w > dead_neg) && (v_w < dead_pos);

    always_comb begin
        o_valid = i_valid;
        o_times = i_times;

        // negative extreme entry and exit
        if (o_valid[snsg_pkg::MK_NEG_START]) begin
            if ((v_w > ext_neg) && !o_valid[snsg_pkg::MK_NEG_END]) begin
                o_valid[snsg_pkg::MK_NEG_END] = 1'b1;
                o_times[snsg_pkg::MK_NEG_END] = i_t;
            end
        end else if (v_w < ext_neg) begin
            o_valid[snsg_pkg::MK_NEG_START] = 1'b1;
            o_times[snsg_pkg::MK_NEG_START] = i_t;
        end

        // positive extreme entry and exit
        if (o_valid[snsg_pkg::MK_POS_START]) begin
            if ((v_w < ext_pos) && !o_valid[snsg_pkg::MK_POS_END]) begin
                o_valid[snsg_pkg::MK_POS_END] = 1'b1;
                o_times[snsg_pkg::MK_POS_END] = i_t;
            end
        end else if (v_w > ext_pos) begin
            o_valid[snsg_pkg::MK_POS_START] = 1'b1;
            o_times[snsg_pkg::MK_POS_START] = i_t;
        end

        // dwell windows
        if (o_valid[snsg_pkg::MK_NEG_END] &&
            out_of(abs_diff(o_times[snsg_pkg::MK_NEG_START], o_times[snsg_pkg::MK_NEG_END]),
                   i_cfg.min_extreme, i_cfg.max_extreme)) begin
            o_valid = '0;
        end
        if (o_valid[snsg_pkg::MK_POS_END] &&
            out_of(abs_diff(o_times[snsg_pkg::MK_POS_START], o_times[snsg_pkg::MK_POS_END]),
                   i_cfg.min_extreme, i_cfg.max_extreme)) begin
            o_valid = '0;
        end

        // centre markers
        if (!o_valid[snsg_pkg::MK_NEG_START] && !o_valid[snsg_pkg::MK_POS_START] && centred) begin
            o_valid[snsg_pkg::MK_START_DEAD] = 1'b1;
            o_times[snsg_pkg::MK_START_DEAD] = i_t;
        end
        if (!o_valid[snsg_pkg::MK_END_DEAD] && o_valid[snsg_pkg::MK_NEG_END] &&
            o_valid[snsg_pkg::MK_POS_END] && centred) begin
            o_valid[snsg_pkg::MK_END_DEAD] = 1'b1;
            o_times[snsg_pkg::MK_END_DEAD] = i_t;
        end

        // whole stroke window
        if (o_valid[snsg_pkg::MK_START_DEAD] && o_valid[snsg_pkg::MK_END_DEAD] &&
            out_of(abs_diff(o_times[snsg_pkg::MK_START_DEAD], o_times[snsg_pkg::MK_END_DEAD]),
                   i_cfg.min_total, i_cfg.max_total)) begin
            o_valid = '0;
        end
    end

endmodule

// File: hw/rtl/stick_nod_shake_gesture_detector.sv
// ----------------------------------------------------------------------------
// stick_nod_shake_gesture_detector: nod (yes) / shake (no) recognizer
// pipeline: a request is held in the input reg, then its verdict in the result reg
// throughput: one request per cycle while the verdict channel is not stalled; the marker update is combinational
// stalls: a held verdict blocks new requests only once the input reg is also full
// reset: synchronous active low; disabled, markers clear, registers at defaults
// ----------------------------------------------------------------------------
module stick_nod_shake_gesture_detector #(
    parameter int STICK_FRAC_BITS = 14,
    parameter int TIME_WIDTH      = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // configuration writes
    input  logic                                 i_cfg_wr_en,
    input  logic [snsg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [snsg_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    // request channel
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [snsg_pkg::OP_W-1:0]            i_op,
    input  logic signed [snsg_pkg::STICK_W-1:0]  i_stick_value,
    input  logic [31:0]                          i_time_now,
    // verdict channel
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [snsg_pkg::VERDICT_W-1:0]       o_verdict
);

    // threshold defaults 0.2 and 0.7 in the stick fixed point format
    localparam int DEAD_RST_I    = (2 * (1 << STICK_FRAC_BITS) + 5) / 10;
    localparam int EXTREME_RST_I = (7 * (1 << STICK_FRAC_BITS) + 5) / 10;
    localparam logic [snsg_pkg::THR_W-1:0] DEAD_RST    = snsg_pkg::THR_W'(DEAD_RST_I);
    localparam logic [snsg_pkg::THR_W-1:0] EXTREME_RST = snsg_pkg::THR_W'(EXTREME_RST_I);

    // configuration registers
    snsg_pkg::t_axis_cfg            r_cfg;
    logic [snsg_pkg::MS_W-1:0]      r_timeout;

    // input register
    logic                                r_in_valid;
    logic [snsg_pkg::OP_W-1:0]           r_op;
    logic signed [snsg_pkg::STICK_W-1:0] r_stick;
    logic [TIME_WIDTH-1:0]               r_time;

    // result register
    logic                                r_out_valid;
    logic [snsg_pkg::VERDICT_W-1:0]      r_verdict;

    // detector state, marker slots split per axis
    logic signed [snsg_pkg::STICK_W-1:0] r_stick_x, n_stick_x;
    logic signed [snsg_pkg::STICK_W-1:0] r_stick_y, n_stick_y;
    logic [snsg_pkg::MARKERS-1:0]        r_x_valid, n_x_valid;
    logic [snsg_pkg::MARKERS-1:0]        r_y_valid, n_y_valid;
    logic [TIME_WIDTH-1:0]               r_x_times [snsg_pkg::MARKERS];
    logic [TIME_WIDTH-1:0]               n_x_times [snsg_pkg::MARKERS];
    logic [TIME_WIDTH-1:0]               r_y_times [snsg_pkg::MARKERS];
    logic [TIME_WIDTH-1:0]               n_y_times [snsg_pkg::MARKERS];
    logic                                r_enabled, n_enabled;
    logic                                r_finished, n_finished;
    logic [TIME_WIDTH-1:0]               r_enable_time, n_enable_time;
    logic [snsg_pkg::VERDICT_W-1:0]      n_verdict;

    // axis update results
    logic signed [snsg_pkg::STICK_W-1:0] smp_x;
    logic signed [snsg_pkg::STICK_W-1:0] smp_y;
    logic [snsg_pkg::MARKERS-1:0]        ax_x_valid;
    logic [snsg_pkg::MARKERS-1:0]        ax_y_valid;
    logic [TIME_WIDTH-1:0]               ax_x_times [snsg_pkg::MARKERS];
    logic [TIME_WIDTH-1:0]               ax_y_times [snsg_pkg::MARKERS];
    logic                                yes_done;
    logic                                no_done;
    logic [TIME_WIDTH-1:0]               since_enable;

    // handshake: the processing stage moves whenever the result register is free
    // or being drained, so a pending request never waits on an idle result slot
    logic advance;
    logic process;

    assign advance     = !r_out_valid || !i_out_stall;
    assign process     = r_in_valid && advance;
    assign o_in_stall  = r_in_valid && !advance;
    assign o_out_valid = r_out_valid;
    assign o_verdict   = r_verdict;

    // configuration writes, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead        <= DEAD_RST;
            r_cfg.extreme     <= EXTREME_RST;
            r_cfg.min_extreme <= snsg_pkg::RST_MIN_EXTREME;
            r_cfg.max_extreme <= snsg_pkg::RST_MAX_EXTREME;
            r_cfg.min_total   <= snsg_pkg::RST_MIN_TOTAL;
            r_cfg.max_total   <= snsg_pkg::RST_MAX_TOTAL;
            r_timeout         <= snsg_pkg::RST_TIMEOUT;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                snsg_pkg::REG_DEAD_THR:    r_cfg.dead        <= i_cfg_data[snsg_pkg::THR_W-1:0];
                snsg_pkg::REG_EXTREME_THR: r_cfg.extreme     <= i_cfg_data[snsg_pkg::THR_W-1:0];
                snsg_pkg::REG_MIN_EXTREME: r_cfg.min_extreme <= i_cfg_data;
                snsg_pkg::REG_MAX_EXTREME: r_cfg.max_extreme <= i_cfg_data;
                snsg_pkg::REG_MIN_TOTAL:   r_cfg.min_total   <= i_cfg_data;
                snsg_pkg::REG_MAX_TOTAL:   r_cfg.max_total   <= i_cfg_data;
                snsg_pkg::REG_TIMEOUT:     r_timeout         <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_op    <= i_op;
            r_stick <= i_stick_value;
            r_time  <= TIME_WIDTH'(i_time_now);
        end
    end

    // the new sample replaces its own axis, the other axis keeps its last value
    assign smp_x = (r_op == snsg_pkg::OP_X_SAMPLE) ? r_stick : r_stick_x;
    assign smp_y = (r_op == snsg_pkg::OP_Y_SAMPLE) ? r_stick : r_stick_y;

    // both axes see every sample, x (shake) and y (nod)
    snsg_axis #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_axis_x (
        .i_cfg   (r_cfg),
        .i_v     (smp_x),
        .i_t     (r_time),
        .i_valid (r_x_valid),
        .i_times (r_x_times),
        .o_valid (ax_x_valid),
        .o_times (ax_x_times)
    );

    snsg_axis #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_axis_y (
        .i_cfg   (r_cfg),
        .i_v     (smp_y),
        .i_t     (r_time),
        .i_valid (r_y_valid),
        .i_times (r_y_times),
        .o_valid (ax_y_valid),
        .o_times (ax_y_times)
    );

    assign yes_done     = ax_y_valid[snsg_pkg::MK_END_DEAD];
    assign no_done      = ax_x_valid[snsg_pkg::MK_END_DEAD];
    assign since_enable = r_time - r_enable_time;

    // request decode and state update
    always_comb begin
        n_stick_x     = r_stick_x;
        n_stick_y     = r_stick_y;
        n_x_valid     = r_x_valid;
        n_y_valid     = r_y_valid;
        n_x_times     = r_x_times;
        n_y_times     = r_y_times;
        n_enabled     = r_enabled;
        n_finished    = r_finished;
        n_enable_time = r_enable_time;
        n_verdict     = snsg_pkg::VERDICT_NONE;

        unique case (r_op) inside
            snsg_pkg::OP_X_SAMPLE, snsg_pkg::OP_Y_SAMPLE: begin
                // samples count only while running
                if (r_enabled && !r_finished) begin
                    n_stick_x = smp_x;
                    n_stick_y = smp_y;
                    n_x_valid = ax_x_valid;
                    n_y_valid = ax_y_valid;
                    n_x_times = ax_x_times;
                    n_y_times = ax_y_times;
                    // any completion wipes the gesture, both at once is a no-call
                    if (yes_done || no_done) begin
                        n_x_valid = '0;
                        n_y_valid = '0;
                        n_stick_x = '0;
                        n_stick_y = '0;
                    end
                    if (yes_done != no_done) begin
                        n_finished = 1'b1;
                        n_verdict  = yes_done ? snsg_pkg::VERDICT_YES : snsg_pkg::VERDICT_NO;
                    end
                end
            end
            snsg_pkg::OP_TICK: begin
                // a clock that went backward never times out
                if (r_enabled && !r_finished && (r_time >= r_enable_time) &&
                    (since_enable > TIME_WIDTH'(r_timeout))) begin
                    n_finished = 1'b1;
                    n_verdict  = snsg_pkg::VERDICT_TIMEOUT;
                end
            end
            snsg_pkg::OP_ENABLE, snsg_pkg::OP_DISABLE: begin
                n_enable_time = r_time;
                n_finished    = 1'b0;
                n_x_valid     = '0;
                n_y_valid     = '0;
                n_stick_x     = '0;
                n_stick_y     = '0;
                n_enabled     = (r_op == snsg_pkg::OP_ENABLE);
            end
            default: ;
        endcase
    end

    // detector state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stick_x     <= '0;
            r_stick_y     <= '0;
            r_x_valid     <= '0;
            r_y_valid     <= '0;
            r_enabled     <= 1'b0;
            r_finished    <= 1'b0;
            r_enable_time <= '0;
        end else if (process) begin
            r_stick_x     <= n_stick_x;
            r_stick_y     <= n_stick_y;
            r_x_valid     <= n_x_valid;
            r_y_valid     <= n_y_valid;
            r_enabled     <= n_enabled;
            r_finished    <= n_finished;
            r_enable_time <= n_enable_time;
        end
    end

    // marker times are read only behind a set valid bit
    always_ff @(posedge i_clk) begin
        if (process) begin
            r_x_times <= n_x_times;
            r_y_times <= n_y_times;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process) begin
            r_verdict <= n_verdict;
        end
    end

    // a pending verdict other than nothing leaves the detector finished
    a_verdict_finishes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_verdict != snsg_pkg::VERDICT_NONE)) |-> r_finished)
        else $error("verdict reported while detector still running");

    // a yes or no wipes every marker
    a_gesture_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && ((r_verdict == snsg_pkg::VERDICT_YES) ||
                         (r_verdict == snsg_pkg::VERDICT_NO)))
        |-> ((r_x_valid == '0) && (r_y_valid == '0)))
        else $error("markers left after a completed gesture");

    // no marker may be placed while disabled
    a_idle_no_markers: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_enabled |-> ((r_x_valid == '0) && (r_y_valid == '0)))
        else $error("markers present while disabled");

    // a blocked request stays in the input register
    a_request_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("blocked request dropped");

endmodule
